@@ rtl/core/gsoc_pkg.sv @@
// Shared types and constants for the gyro still-offset calibrator.
package gsoc_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int NUM_AXES       = 3;
  localparam int GYRO_W         = 16;
  localparam int STEP_W         = 16;
  localparam int DUR_W          = 32;
  localparam int LIMIT_W        = 31;
  localparam int CFG_IDX_W      = 2;

  localparam logic [DUR_W-1:0]   DURATION_RST  = 32'd3000000;
  localparam logic [LIMIT_W-1:0] VAR_LIMIT_RST = 31'd100;

  localparam logic [CFG_IDX_W-1:0] REG_DURATION    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VAR_LIMIT_X = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VAR_LIMIT_Y = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VAR_LIMIT_Z = 2'd3;

  // per-lane control from the sequencer
  typedef struct packed {
    logic acc;    // add the sample to the sums
    logic clr;    // clear the sums
    logic start;  // close the window: start mean/variance
  } lane_ctl_t;

  // per-lane verdict at window close
  typedef struct packed {
    logic                     valid;
    logic                     ok;
    logic signed [GYRO_W-1:0] mean;
  } lane_res_t;

endpackage

@@ rtl/core/gsoc_lane.sv @@
// One axis lane: sum and sum of squares, bit-serial divide, variance check.
module gsoc_lane #(
  parameter int COUNT_BITS = gsoc_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  gsoc_pkg::lane_ctl_t                 ctl,
  input  logic signed [gsoc_pkg::GYRO_W-1:0]  sample,
  input  logic [COUNT_BITS-1:0]               count,
  input  logic [gsoc_pkg::LIMIT_W-1:0]        limit,
  output gsoc_pkg::lane_res_t                 res
);

  localparam int SUM_W = COUNT_BITS + 16;
  localparam int SQ_W  = COUNT_BITS + 31;
  localparam int CNT_W = $clog2(SQ_W + 1);
  localparam int Q_W   = 17;

  logic signed [SUM_W-1:0] sum;
  logic [SQ_W-1:0]         sqsum;
  logic signed [31:0]      prod;

  logic [SQ_W-1:0]         dv_a, dv_b;
  logic [COUNT_BITS-1:0]   rem_a, rem_b, divisor;
  logic [CNT_W-1:0]        step_cnt;
  logic                    neg, busy, sq_ph, chk_ph;
  logic [2*Q_W-1:0]        sq;
  logic signed [15:0]      mean;
  logic [SUM_W-1:0]        mag;

  logic [COUNT_BITS:0]     ta, tb, dsr;
  logic                    ge_a, ge_b;
  logic [COUNT_BITS:0]     ra_next, rb_next;
  logic [Q_W-1:0]          qa;
  logic [SQ_W-1:0]         sq_ext, diff;

  assign prod = sample * sample;
  assign mag  = sum[SUM_W-1] ? $unsigned(-sum) : $unsigned(sum);

  // restoring divide, one quotient bit per cycle for both dividends
  assign dsr     = {1'b0, divisor};
  assign ta      = {rem_a, dv_a[SQ_W-1]};
  assign tb      = {rem_b, dv_b[SQ_W-1]};
  assign ge_a    = (ta >= dsr);
  assign ge_b    = (tb >= dsr);
  assign ra_next = ge_a ? ta - dsr : ta;
  assign rb_next = ge_b ? tb - dsr : tb;

  assign qa     = dv_a[Q_W-1:0];
  assign sq_ext = {{(SQ_W-2*Q_W){1'b0}}, sq};
  assign diff   = (dv_b >= sq_ext) ? dv_b - sq_ext : '0;

  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      sum   <= '0;
      sqsum <= '0;
    end else if (ctl.acc) begin
      sum   <= sum + {{(SUM_W-16){sample[15]}}, sample};
      sqsum <= sqsum + {{(SQ_W-32){1'b0}}, $unsigned(prod)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      sq_ph  <= 1'b0;
      chk_ph <= 1'b0;
    end else begin
      chk_ph <= sq_ph;
      sq_ph  <= busy && (step_cnt == CNT_W'(1));
      if (ctl.start) begin
        busy <= 1'b1;
      end else if (busy && (step_cnt == CNT_W'(1))) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      dv_a     <= {{(SQ_W-SUM_W){1'b0}}, mag};
      dv_b     <= sqsum;
      rem_a    <= '0;
      rem_b    <= '0;
      divisor  <= count;
      neg      <= sum[SUM_W-1];
      step_cnt <= CNT_W'(SQ_W);
    end else if (busy) begin
      dv_a     <= {dv_a[SQ_W-2:0], ge_a};
      dv_b     <= {dv_b[SQ_W-2:0], ge_b};
      rem_a    <= ra_next[COUNT_BITS-1:0];
      rem_b    <= rb_next[COUNT_BITS-1:0];
      step_cnt <= step_cnt - CNT_W'(1);
    end
    if (sq_ph) begin
      sq   <= qa * qa;
      mean <= neg ? -$signed(qa[15:0]) : $signed(qa[15:0]);
    end
    if (chk_ph) begin
      res.ok   <= (diff <= {{(SQ_W-gsoc_pkg::LIMIT_W){1'b0}}, limit});
      res.mean <= mean;
    end
    if (rst) begin
      res.valid <= 1'b0;
    end else begin
      res.valid <= chk_ph;
    end
  end

endmodule

@@ rtl/core/gsoc_merge.sv @@
// Combines the lane verdicts and holds the latched offsets.
module gsoc_merge (
  input  logic                               clk,
  input  gsoc_pkg::lane_res_t                res [gsoc_pkg::NUM_AXES],
  input  logic                               commit,
  output logic                               ok,
  output logic signed [gsoc_pkg::GYRO_W-1:0] cap_mean [gsoc_pkg::NUM_AXES],
  output logic signed [gsoc_pkg::GYRO_W-1:0] store [gsoc_pkg::NUM_AXES]
);

  logic all_ok;

  always_comb begin
    all_ok = 1'b1;
    for (int i = 0; i < gsoc_pkg::NUM_AXES; i++) begin
      all_ok = all_ok & res[i].ok;
    end
  end

  always_ff @(posedge clk) begin
    if (res[0].valid) begin
      ok <= all_ok;
      for (int i = 0; i < gsoc_pkg::NUM_AXES; i++) begin
        cap_mean[i] <= res[i].mean;
      end
    end
    if (commit && ok) begin
      for (int i = 0; i < gsoc_pkg::NUM_AXES; i++) begin
        store[i] <= cap_mean[i];
      end
    end
  end

endmodule

@@ rtl/core/gyro_still_offset_calibrator.sv @@
// Top level: window timing, sequencing, three axis lanes and the verdict merge.
//
//  port group   dir  contents (low bit first)
//  s_axis_*     in   tdata: step_us, gyro_x, gyro_y, gyro_z
//  m_axis_*     out  tuser: restarted, finished; tdata: offset_x, offset_y, offset_z
//  cfg_*        in   write: index 0 duration_us, 1..3 var_limit_x/y/z
//
// An ordinary sample's word is registered at acceptance. The word for the
// window-closing sample waits on the bit-serial divider in each lane (one
// quotient bit per cycle), then on the square and the variance check. Input
// is held off while a window close is in progress and while an undelivered
// output word cannot be replaced. rst is synchronous.
module gyro_still_offset_calibrator #(
  parameter int COUNT_BITS = gsoc_pkg::COUNT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [63:0]                        s_axis_tdata,  // step_us, gyro_x, gyro_y, gyro_z
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [47:0]                        m_axis_tdata,  // offset_x, offset_y, offset_z
  output logic [1:0]                         m_axis_tuser,  // restarted, finished
  input  logic                               cfg_we,
  input  logic [gsoc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gsoc_pkg::DUR_W-1:0]         cfg_data
);

  localparam int N = gsoc_pkg::NUM_AXES;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_BUSY = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t state, state_next;

  logic [gsoc_pkg::DUR_W-1:0]   duration;
  logic [gsoc_pkg::LIMIT_W-1:0] limit [N];
  logic [gsoc_pkg::DUR_W-1:0]   elapsed;
  logic [COUNT_BITS-1:0]        count;
  logic                         done;

  logic [gsoc_pkg::STEP_W-1:0]         step;
  logic signed [gsoc_pkg::GYRO_W-1:0]  gyro [N];
  logic [gsoc_pkg::DUR_W:0]            elapsed_sum;
  logic [gsoc_pkg::DUR_W-1:0]          elapsed_next;
  logic                                accept, active, closing, empty, count_full, space;
  logic                                restart_now, fin_load;

  gsoc_pkg::lane_ctl_t                 lctl;
  gsoc_pkg::lane_res_t                 lres [N];
  logic                                ok;
  logic signed [gsoc_pkg::GYRO_W-1:0]  cap_mean [N];
  logic signed [gsoc_pkg::GYRO_W-1:0]  store [N];

  assign step    = s_axis_tdata[15:0];
  assign gyro[0] = s_axis_tdata[31:16];
  assign gyro[1] = s_axis_tdata[47:32];
  assign gyro[2] = s_axis_tdata[63:48];

  assign space         = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == S_IDLE) && space;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign active        = accept && !done;

  // saturating elapsed time
  assign elapsed_sum  = {1'b0, elapsed} + {{(gsoc_pkg::DUR_W-gsoc_pkg::STEP_W+1){1'b0}}, step};
  assign elapsed_next = elapsed_sum[gsoc_pkg::DUR_W] ? '1 : elapsed_sum[gsoc_pkg::DUR_W-1:0];
  assign closing      = elapsed_next >= duration;
  assign empty        = (count == '0);
  assign count_full   = (count == '1);
  assign restart_now  = active && closing && empty;
  assign fin_load     = (state == S_FIN) && space;

  assign lctl.acc   = active && !closing && !count_full;
  assign lctl.start = active && closing && !empty;
  assign lctl.clr   = restart_now || (fin_load && !ok);

  always_ff @(posedge clk) begin
    if (rst) begin
      duration <= gsoc_pkg::DURATION_RST;
      for (int i = 0; i < N; i++) begin
        limit[i] <= gsoc_pkg::VAR_LIMIT_RST;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        gsoc_pkg::REG_DURATION:    duration <= cfg_data;
        gsoc_pkg::REG_VAR_LIMIT_X: limit[0] <= cfg_data[gsoc_pkg::LIMIT_W-1:0];
        gsoc_pkg::REG_VAR_LIMIT_Y: limit[1] <= cfg_data[gsoc_pkg::LIMIT_W-1:0];
        gsoc_pkg::REG_VAR_LIMIT_Z: limit[2] <= cfg_data[gsoc_pkg::LIMIT_W-1:0];
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (lctl.start) state_next = S_BUSY;
      S_BUSY:  if (lres[0].valid) state_next = S_FIN;
      S_FIN:   if (space) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      elapsed <= '0;
      count   <= '0;
      done    <= 1'b0;
    end else begin
      state <= state_next;
      if (lctl.clr) begin
        elapsed <= '0;
        count   <= '0;
      end else if (active) begin
        elapsed <= elapsed_next;
        if (lctl.acc) begin
          count <= count + COUNT_BITS'(1);
        end
      end
      if (fin_load && ok) begin
        done <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (fin_load || (accept && !lctl.start)) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      m_axis_tuser <= {ok, !ok};
      m_axis_tdata <= ok ? {cap_mean[2], cap_mean[1], cap_mean[0]} : '0;
    end else if (accept && !lctl.start) begin
      m_axis_tuser <= {done, restart_now};
      m_axis_tdata <= done ? {store[2], store[1], store[0]} : '0;
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_lane
    gsoc_lane #(
      .COUNT_BITS(COUNT_BITS)
    ) u_lane (
      .clk    (clk),
      .rst    (rst),
      .ctl    (lctl),
      .sample (gyro[g]),
      .count  (count),
      .limit  (limit[g]),
      .res    (lres[g])
    );
  end

  gsoc_merge u_merge (
    .clk      (clk),
    .res      (lres),
    .commit   (fin_load),
    .ok       (ok),
    .cap_mean (cap_mean),
    .store    (store)
  );

  a_lanes_in_step: assert property (@(posedge clk) disable iff (rst)
    (lres[0].valid == lres[1].valid) && (lres[0].valid == lres[2].valid))
    else $error("axis lanes out of step");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    lctl.start |=> (state == S_BUSY))
    else $error("window close did not enter busy");

  a_res_in_busy: assert property (@(posedge clk) disable iff (rst)
    lres[0].valid |-> (state == S_BUSY))
    else $error("lane verdict outside busy");

  a_done_sticks: assert property (@(posedge clk) disable iff (rst)
    done |=> done)
    else $error("finished flag dropped");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("restart and finish in one word");

endmodule

@@ verif/gyro_still_offset_calibrator_tb.sv @@
// Self-checking stream testbench for the gyro still-offset calibrator.
module gyro_still_offset_calibrator_tb;

  // narrow sample counter so that count saturation is reachable in a short run
  localparam int CNT_W = 8;
  localparam longint unsigned COUNT_MAX = (64'd1 << CNT_W) - 1;
  localparam int LIMIT_CYCLES = 2000000;
  localparam int PHASES = 8;
  localparam int PHASE_WORDS = 150;
  localparam int SAT_WORDS = 270;

  // input word, step_us in the low bits
  typedef struct packed {
    logic signed [15:0] gz;
    logic signed [15:0] gy;
    logic signed [15:0] gx;
    logic [15:0]        step_us;
  } gyro_word_t;

  typedef struct {
    logic        restarted;
    logic        finished;
    logic [15:0] ox;
    logic [15:0] oy;
    logic [15:0] oz;
  } calib_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;   // step_us, gyro_x, gyro_y, gyro_z
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // offset_x, offset_y, offset_z
  logic [1:0]  m_axis_tuser;        // restarted, finished
  logic                           cfg_we = 1'b0;
  logic [gsoc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [gsoc_pkg::DUR_W-1:0]     cfg_data = '0;

  gyro_still_offset_calibrator #(.COUNT_BITS(CNT_W)) dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // register mirror
  logic [gsoc_pkg::DUR_W-1:0]   cfg_duration = gsoc_pkg::DURATION_RST;
  logic [gsoc_pkg::LIMIT_W-1:0] cfg_limit[3] = '{gsoc_pkg::VAR_LIMIT_RST,
                                                 gsoc_pkg::VAR_LIMIT_RST,
                                                 gsoc_pkg::VAR_LIMIT_RST};

  // calibrator state as predicted
  logic [31:0]        cal_elapsed = '0;
  longint unsigned    cal_count = 0;
  longint             cal_sum[3] = '{0, 0, 0};
  longint unsigned    cal_sqsum[3] = '{0, 0, 0};
  logic               cal_done = 1'b0;
  logic signed [15:0] cal_off[3] = '{0, 0, 0};

  calib_res_t expected_results[$];
  gyro_word_t pending_words[$];
  int words_queued = 0;
  int words_taken = 0;
  int errors = 0;
  int cycles = 0;

  // window tracking on the stimulus side, used only to avoid closing a window
  // that holds a single sample (zero variance would finish calibration early)
  longint unsigned plan_elapsed = 0;
  int              plan_count = 0;
  logic            x_high = 1'b0;

  logic gaps_on = 1'b1;
  logic hold_req = 1'b0;
  logic rx_hold = 1'b0;
  int   tx_gap = 0;
  int   rx_stall = 0;
  logic word_taken = 1'b0;

  calib_res_t  want_res;
  logic [15:0] want_f[5];
  logic [15:0] seen_f[5];
  string       field_name[5] = '{"restarted", "finished", "offset_x", "offset_y", "offset_z"};

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic calib_predict(input gyro_word_t w);
    longint unsigned    t, mag, quot, msq, sq;
    longint             ax[3];
    logic signed [15:0] mean[3];
    logic               bad;
    calib_res_t         r;
    int                 i;
    ax[0] = w.gx;
    ax[1] = w.gy;
    ax[2] = w.gz;
    mean = '{0, 0, 0};
    r = '{default: '0};
    if (!cal_done) begin
      t = cal_elapsed + w.step_us;
      cal_elapsed = (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
      if (cal_elapsed >= cfg_duration) begin
        bad = (cal_count == 0);
        for (i = 0; i < 3; i++) begin
          if (cal_count != 0) begin
            mag = (cal_sum[i] < 0) ? -cal_sum[i] : cal_sum[i];
            quot = mag / cal_count;
            msq = cal_sqsum[i] / cal_count;
            sq = quot * quot;
            msq = (msq >= sq) ? msq - sq : 0;
            // mean truncates toward zero
            mean[i] = (cal_sum[i] < 0) ? -quot[15:0] : quot[15:0];
            if (msq > cfg_limit[i]) bad = 1'b1;
          end
        end
        if (bad) begin
          cal_elapsed = '0;
          cal_count = 0;
          for (i = 0; i < 3; i++) begin
            cal_sum[i] = 0;
            cal_sqsum[i] = 0;
          end
          r.restarted = 1'b1;
        end else begin
          cal_off = mean;
          cal_done = 1'b1;
        end
      end else if (cal_count < COUNT_MAX) begin
        for (i = 0; i < 3; i++) begin
          cal_sum[i] += ax[i];
          cal_sqsum[i] += ax[i] * ax[i];
        end
        cal_count++;
      end
    end
    r.finished = cal_done;
    if (cal_done) begin
      r.ox = cal_off[0];
      r.oy = cal_off[1];
      r.oz = cal_off[2];
    end
    expected_results.push_back(r);
  endtask

  task automatic queue_sample(input logic [15:0] dt, input logic [15:0] gx, gy, gz);
    gyro_word_t      w;
    longint unsigned t;
    w.step_us = dt;
    w.gx = gx;
    w.gy = gy;
    w.gz = gz;
    pending_words.push_back(w);
    words_queued++;
    t = plan_elapsed + dt;
    if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
    if (t >= cfg_duration) begin
      plan_elapsed = 0;
      plan_count = 0;
    end else begin
      plan_elapsed = t;
      plan_count++;
    end
  endtask

  // x alternates between large positive and large negative values, so every
  // window of two or more samples has a variance far above the limits used
  task automatic queue_random(input logic [15:0] dt);
    logic [15:0] gx;
    if (plan_count == 1 && plan_elapsed + dt >= cfg_duration)
      dt = 16'(cfg_duration - plan_elapsed - 1);
    gx = x_high ? 16'($urandom_range(16384, 32767)) : 16'(65536 - $urandom_range(16384, 32768));
    x_high = ~x_high;
    queue_sample(dt, gx, 16'($urandom), 16'($urandom));
  endtask

  task automatic cfg_write(input logic [gsoc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [gsoc_pkg::DUR_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      gsoc_pkg::REG_DURATION:    cfg_duration = val;
      gsoc_pkg::REG_VAR_LIMIT_X: cfg_limit[0] = val[gsoc_pkg::LIMIT_W-1:0];
      gsoc_pkg::REG_VAR_LIMIT_Y: cfg_limit[1] = val[gsoc_pkg::LIMIT_W-1:0];
      gsoc_pkg::REG_VAR_LIMIT_Z: cfg_limit[2] = val[gsoc_pkg::LIMIT_W-1:0];
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (words_taken != words_queued || expected_results.size() != 0) @(negedge clk);
    repeat (CNT_W + 45) @(negedge clk);
  endtask

  // sender
  always @(negedge clk) begin
    if (!rst && !(s_axis_tvalid && !word_taken)) begin
      if (tx_gap > 0) begin
        tx_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        s_axis_tdata <= pending_words.pop_front();
        s_axis_tvalid <= 1'b1;
        tx_gap = gaps_on ? idle_len() : 0;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    word_taken = 1'b0;
  end

  // receiver
  always @(negedge clk) begin
    if (rx_hold) begin
      m_axis_tready <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (gaps_on && $urandom_range(0, 3) == 0) rx_stall = idle_len();
    end
  end

  // long receiver hold-off while the sender keeps offering words
  initial begin
    forever begin
      wait (hold_req);
      rx_hold = 1'b1;
      repeat (400) @(posedge clk);
      rx_hold = 1'b0;
      hold_req = 1'b0;
    end
  end

  // monitor: check the outgoing word first, then predict for the incoming one
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: expected no word, actual tuser %b tdata %h",
                   $time, m_axis_tuser, m_axis_tdata);
          errors++;
        end else begin
          want_res = expected_results.pop_front();
          want_f = '{want_res.restarted, want_res.finished, want_res.ox, want_res.oy, want_res.oz};
          seen_f = '{m_axis_tuser[0], m_axis_tuser[1], m_axis_tdata[15:0],
                     m_axis_tdata[31:16], m_axis_tdata[47:32]};
          for (int i = 0; i < 5; i++) begin
            if (want_f[i] !== seen_f[i]) begin
              $display("%0t: %s expected %0h, actual %0h",
                       $time, field_name[i], want_f[i], seen_f[i]);
              errors++;
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        calib_predict(gyro_word_t'(s_axis_tdata));
        words_taken++;
        word_taken = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    logic [gsoc_pkg::DUR_W-1:0] dur;
    int                         cap;
    logic [15:0]                dt;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: field extremes, window stays open
    queue_sample(16'h0000, 16'h8000, 16'h7FFF, 16'h0000);
    queue_sample(16'hFFFF, 16'h7FFF, 16'h8000, 16'hFFFF);
    queue_sample(16'h0001, 16'h0000, 16'h0000, 16'h7FFF);
    wait_drained();

    // zero-length window: closes the open window, then empty windows
    cfg_write(gsoc_pkg::REG_VAR_LIMIT_X, 32'd0);
    cfg_write(gsoc_pkg::REG_VAR_LIMIT_Y, 32'd1073741824);
    cfg_write(gsoc_pkg::REG_DURATION, 32'd0);
    queue_sample(16'h0000, 16'h1234, 16'h8000, 16'h7FFF);
    queue_sample(16'h0000, 16'h0001, 16'h0002, 16'h0003);
    queue_sample(16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000);
    wait_drained();

    // elapsed time lands exactly on the window length; negative sums
    cfg_write(gsoc_pkg::REG_DURATION, 32'd100);
    queue_sample(16'd10, 16'hFFFD, 16'h8000, 16'd5);
    queue_sample(16'd10, 16'hFFFC, 16'h7FFF, 16'd5);
    queue_sample(16'd79, 16'hFFFC, 16'h0000, 16'd6);
    queue_sample(16'd1, 16'h5555, 16'hAAAA, 16'h0F0F);
    wait_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      // a shorter window must not close a single-sample window
      if (plan_count == 1) begin
        queue_random(16'd0);
        wait_drained();
      end
      case ($urandom_range(0, 4))
        0: begin dur = $urandom_range(1, 4); cap = 1; end
        1: begin dur = $urandom_range(5, 2000); cap = dur / 8; end
        2: begin dur = $urandom_range(2000, 200000); cap = dur / 12; end
        3: begin dur = $urandom_range(200000, 3000000); cap = 300; end
        default: begin dur = gsoc_pkg::DURATION_RST; cap = 65535; end
      endcase
      cfg_write(gsoc_pkg::REG_DURATION, dur);
      cfg_write(gsoc_pkg::REG_VAR_LIMIT_X,
                (ph == 0) ? 32'd0 : $urandom_range(0, 32'h0800_0000));
      cfg_write(gsoc_pkg::REG_VAR_LIMIT_Y,
                (ph == 0) ? 32'd0 : $urandom_range(0, 32'h0800_0000));
      cfg_write(gsoc_pkg::REG_VAR_LIMIT_Z,
                (ph == 0) ? 32'd0 : $urandom_range(0, 32'h0800_0000));
      gaps_on = (ph % 3 != 2);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        case ($urandom_range(0, 9))
          0: dt = '0;
          1: dt = '1;
          2: dt = 16'($urandom);
          default: dt = 16'($urandom_range(0, (cap < 1) ? 1 : cap));
        endcase
        queue_random(dt);
      end
      if (ph == 1) hold_req = 1'b1;
      wait_drained();
    end

    // never close a single-sample window; then close whatever is open
    if (plan_count == 1) queue_random(16'd0);
    wait_drained();
    cfg_write(gsoc_pkg::REG_DURATION, 32'd0);
    queue_random(16'd0);
    wait_drained();

    // long window: the sample count saturates before the window closes
    gaps_on = 1'b0;
    cfg_write(gsoc_pkg::REG_DURATION, 32'hFFFF_FFFF);
    for (int n = 0; n < SAT_WORDS; n++) queue_random(16'hFFFF);
    wait_drained();
    cfg_write(gsoc_pkg::REG_DURATION, 32'd0);
    queue_random(16'd0);
    wait_drained();

    // clean window that passes on the limit boundaries, then ignored samples
    gaps_on = 1'b1;
    cfg_write(gsoc_pkg::REG_DURATION, 32'd21);
    cfg_write(gsoc_pkg::REG_VAR_LIMIT_X, 32'd0);
    cfg_write(gsoc_pkg::REG_VAR_LIMIT_Y, 32'd1);
    cfg_write(gsoc_pkg::REG_VAR_LIMIT_Z, 32'd1073741824);
    for (int n = 0; n < 20; n++)
      queue_sample(16'd1, 16'h8000, (n % 2) ? 16'd32765 : 16'd32767,
                   16'(65536 - $urandom_range(1, 7)));
    queue_sample(16'hFFFF, 16'($urandom), 16'($urandom), 16'($urandom));
    for (int n = 0; n < 20; n++)
      queue_sample(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    wait_drained();

    if (errors == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ gyro_still_offset_calibrator.f @@
rtl/core/gsoc_pkg.sv
rtl/core/gsoc_lane.sv
rtl/core/gsoc_merge.sv
rtl/core/gyro_still_offset_calibrator.sv
verif/gyro_still_offset_calibrator_tb.sv
